// File: src/rfuc_pkg.sv
// remote-control frame unpack/check: shared types and constants
// no dependencies; used by every module of the block
`default_nettype none

package rfuc_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned STORE_LEN = 17;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned STICK_W   = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_LEN - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 2'd1;

  localparam logic [CH_W-1:0] OFFSET_RESET = 11'd1024;
  localparam logic [CH_W-1:0] LIMIT_RESET  = 11'd660;

  // switch position forced on a bad frame
  localparam logic [1:0] SW_DOWN = 2'd2;

  // tdata width of the result: 150 payload bits rounded up to whole bytes
  localparam int unsigned RES_BITS = 150;
  localparam int unsigned RES_TDATA_W = 152;

  typedef logic [FRAME_LEN-1:0][7:0] rfuc_frame_t;

  // completed frame handed from the byte store to the result stage
  typedef struct packed {
    logic        done;
    rfuc_frame_t bytes;
  } rfuc_frame_beat_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick_0;
    logic signed [STICK_W-1:0] stick_1;
    logic signed [STICK_W-1:0] stick_2;
    logic signed [STICK_W-1:0] stick_3;
    logic signed [15:0]        wheel_channel;
    logic [5:0]                switches_buttons;
    logic signed [15:0]        mouse_x;
    logic signed [15:0]        mouse_y;
    logic signed [15:0]        mouse_z;
    logic [15:0]               key_bits;
    logic [15:0]               key_rising;
    logic                      frame_bad;
  } rfuc_result_t;

endpackage

`default_nettype wire

// File: src/rfuc_byte_store.sv
// byte counter and frame store: collects bytes 0..16, flags the closing byte
// depends on rfuc_pkg
`default_nettype none

module rfuc_byte_store
  import rfuc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             start_i,
  output logic                  at_last_o,
  output rfuc_frame_beat_t      frame_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pos;
  logic [7:0]       store_q [STORE_LEN];
  logic             is_last;

  always_comb begin
    if (start_i || (idx_q >= IDX_W'(FRAME_LEN))) begin
      pos = '0;
    end else begin
      pos = idx_q;
    end
  end

  assign is_last   = (pos == LAST_POS);
  assign at_last_o = (idx_q == LAST_POS);

  always_comb begin
    idx_d = idx_q;
    if (accept_i) begin
      idx_d = is_last ? '0 : pos + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !is_last) begin
      store_q[pos] <= byte_i;
    end
  end

  always_comb begin
    frame_o.done = accept_i && is_last;
    for (int i = 0; i < STORE_LEN; i++) begin
      frame_o.bytes[i] = store_q[i];
    end
    // closing byte comes straight from the input beat
    frame_o.bytes[FRAME_LEN-1] = byte_i;
  end

endmodule

`default_nettype wire

// File: src/rfuc_decode.sv
// combinational unpack and range/switch check of one complete frame
// depends on rfuc_pkg
`default_nettype none

module rfuc_decode
  import rfuc_pkg::*;
(
  input  wire rfuc_frame_t      frame_i,
  input  wire logic [CH_W-1:0]  offset_i,
  input  wire logic [CH_W-1:0]  limit_i,
  input  wire logic [15:0]      prev_keys_i,
  output rfuc_result_t          result_o
);

  logic [CH_W-1:0]           raw   [4];
  logic signed [STICK_W-1:0] st    [4];
  logic [CH_W-1:0]           mag   [4];
  logic [3:0]                over;
  logic [1:0]                sw_l, sw_r;
  logic [15:0]               keys;
  logic                      bad;

  assign raw[0] = {frame_i[1][2:0], frame_i[0]};
  assign raw[1] = {frame_i[2][5:0], frame_i[1][7:3]};
  assign raw[2] = {frame_i[4][0], frame_i[3], frame_i[2][7:6]};
  assign raw[3] = {frame_i[5][3:0], frame_i[4][7:1]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      st[k]   = $signed({1'b0, raw[k]}) - $signed({1'b0, offset_i});
      // |st| never exceeds 2047, so 11 bits hold it
      mag[k]  = st[k][STICK_W-1] ? CH_W'(-st[k]) : st[k][CH_W-1:0];
      over[k] = (mag[k] > limit_i);
    end
  end

  assign sw_l = frame_i[5][5:4];
  assign sw_r = frame_i[5][7:6];
  assign keys = {frame_i[15], frame_i[14]};
  assign bad  = (|over) || (sw_l == 2'd0) || (sw_r == 2'd0);

  always_comb begin
    if (bad) begin
      result_o                  = '0;
      result_o.switches_buttons = {2'b00, SW_DOWN, SW_DOWN};
      result_o.frame_bad        = 1'b1;
    end else begin
      result_o.stick_0          = st[0];
      result_o.stick_1          = st[1];
      result_o.stick_2          = st[2];
      result_o.stick_3          = st[3];
      result_o.wheel_channel    = {frame_i[17], frame_i[16]} - {5'd0, offset_i};
      result_o.switches_buttons = {(frame_i[13] != 8'd0), (frame_i[12] != 8'd0), sw_r, sw_l};
      result_o.mouse_x          = {frame_i[7], frame_i[6]};
      result_o.mouse_y          = {frame_i[9], frame_i[8]};
      result_o.mouse_z          = {frame_i[11], frame_i[10]};
      result_o.key_bits         = keys;
      result_o.key_rising       = keys & ~prev_keys_i;
      result_o.frame_bad        = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/rfuc_result_stage.sv
// result register with previous-key history; decodes a closing frame beat
// depends on rfuc_pkg and rfuc_decode
`default_nettype none

module rfuc_result_stage
  import rfuc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rfuc_frame_beat_t frame_i,
  input  wire logic [CH_W-1:0]  offset_i,
  input  wire logic [CH_W-1:0]  limit_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output rfuc_result_t          out_o,
  output logic                  room_o
);

  logic         valid_q, valid_d;
  rfuc_result_t res_q;
  rfuc_result_t res_d;
  logic [15:0]  prev_keys_q, prev_keys_d;

  rfuc_decode u_decode (
    .frame_i     (frame_i.bytes),
    .offset_i    (offset_i),
    .limit_i     (limit_i),
    .prev_keys_i (prev_keys_q),
    .result_o    (res_d)
  );

  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d     = valid_q;
    prev_keys_d = prev_keys_q;
    if (frame_i.done) begin
      valid_d     = 1'b1;
      prev_keys_d = res_d.key_bits;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      prev_keys_q <= '0;
    end else begin
      valid_q     <= valid_d;
      prev_keys_q <= prev_keys_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.done) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// File: src/remote_frame_unpack_check_core.sv
// remote-control frame unpack/check: top level with config registers
// result valid in the cycle after the closing (18th) byte beat is accepted
// throughput: one byte beat per cycle unless a closing byte waits; one result per 18 bytes
// a byte arriving after 17 stored bytes waits while a previous result is still stalled
// reset: byte count and key history cleared, offset 1024, limit 660, no result
`default_nettype none

module remote_frame_unpack_check_core
  import rfuc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // data_byte
  input  wire logic                   s_axis_tuser,  // frame_start
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // stick_0, stick_1, stick_2, stick_3, wheel_channel, switches_buttons,
  // mouse_x, mouse_y, mouse_z, key_bits, key_rising, zero pad
  output logic [RES_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tuser,  // frame_bad
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CH_W-1:0]        cfg_data_i
);

  logic [CH_W-1:0]  offset_q, offset_d;
  logic [CH_W-1:0]  limit_q, limit_d;
  logic             accept;
  logic             at_last;
  logic             room;
  rfuc_frame_beat_t frame_beat;
  rfuc_result_t     res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    offset_d = offset_q;
    limit_d  = limit_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_OFFSET: offset_d = cfg_data_i;
        CFG_ERROR_LIMIT:    limit_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      limit_q  <= LIMIT_RESET;
    end else begin
      offset_q <= offset_d;
      limit_q  <= limit_d;
    end
  end

  // only a byte that may close a frame needs room in the result register
  assign s_axis_tready = !at_last || room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rfuc_byte_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata),
    .start_i   (s_axis_tuser),
    .at_last_o (at_last),
    .frame_o   (frame_beat)
  );

  rfuc_result_stage u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_beat),
    .offset_i    (offset_q),
    .limit_i     (limit_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res),
    .room_o      (room)
  );

  assign m_axis_tdata = {
    (RES_TDATA_W - RES_BITS)'(0),
    res.key_rising,
    res.key_bits,
    res.mouse_z,
    res.mouse_y,
    res.mouse_x,
    res.switches_buttons,
    res.wheel_channel,
    res.stick_3,
    res.stick_2,
    res.stick_1,
    res.stick_0
  };
  assign m_axis_tuser = res.frame_bad;

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for remote_frame_unpack_check_core: byte stream in, unpacked frame out
// keeps its own frame decoder and key history to predict each result and compares field by field
// depends on rfuc_pkg and remote_frame_unpack_check_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfuc_pkg::*;

  localparam int unsigned RUN_LIMIT = 200000;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [RES_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CH_W-1:0]        cfg_data_i;

  remote_frame_unpack_check_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // decoder state mirrored on the testbench side
  logic [IDX_W-1:0] frame_pos = '0;
  rfuc_frame_t      frame_bytes = '0;
  logic [15:0]      last_keys = '0;
  logic [CH_W-1:0]  cur_offset = OFFSET_RESET;
  logic [CH_W-1:0]  cur_limit = LIMIT_RESET;
  rfuc_result_t     expected_frames[$];

  rfuc_result_t want;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  stall_left = 0;
  bit           idle_en = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side back-pressure in bursts that start at random
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no frame pending, expected none got %h",
                 $time, m_axis_tdata);
      end else begin
        want = expected_frames.pop_front();
        report_field("stick_0", $unsigned(want.stick_0), m_axis_tdata[11:0]);
        report_field("stick_1", $unsigned(want.stick_1), m_axis_tdata[23:12]);
        report_field("stick_2", $unsigned(want.stick_2), m_axis_tdata[35:24]);
        report_field("stick_3", $unsigned(want.stick_3), m_axis_tdata[47:36]);
        report_field("wheel_channel", want.wheel_channel, m_axis_tdata[63:48]);
        report_field("switches_buttons", want.switches_buttons, m_axis_tdata[69:64]);
        report_field("mouse_x", want.mouse_x, m_axis_tdata[85:70]);
        report_field("mouse_y", want.mouse_y, m_axis_tdata[101:86]);
        report_field("mouse_z", want.mouse_z, m_axis_tdata[117:102]);
        report_field("key_bits", want.key_bits, m_axis_tdata[133:118]);
        report_field("key_rising", want.key_rising, m_axis_tdata[149:134]);
        report_field("frame_bad", want.frame_bad, m_axis_tuser);
      end
    end
  end

  // advance the mirrored decoder by one byte; queue a result when a frame closes
  task automatic decode_byte(input logic [7:0] data, input logic start);
    logic [IDX_W-1:0] pos;
    logic [47:0]      head;
    logic [10:0]      raw;
    logic [11:0]      sticks[4];
    logic [1:0]       sw_l;
    logic [1:0]       sw_r;
    logic [15:0]      keys;
    int               dev;
    int               mag;
    int               k;
    logic             bad;
    rfuc_result_t     res;
    pos = start ? '0 : frame_pos;
    if (pos >= FRAME_LEN) pos = '0;
    if (pos != LAST_POS) begin
      frame_bytes[pos] = data;
      frame_pos = pos + 1'b1;
      return;
    end
    frame_pos = '0;
    frame_bytes[LAST_POS] = data;
    head = frame_bytes[5:0];
    bad = 1'b0;
    for (k = 0; k < 4; k++) begin
      raw = head[11*k +: 11];
      dev = int'(raw) - int'(cur_offset);
      mag = (dev < 0) ? -dev : dev;
      if (mag > int'(cur_limit)) bad = 1'b1;
      sticks[k] = dev[11:0];
    end
    sw_l = head[45:44];
    sw_r = head[47:46];
    if (sw_l == 2'd0 || sw_r == 2'd0) bad = 1'b1;
    res = '0;
    if (bad) begin
      res.switches_buttons = {2'b00, SW_DOWN, SW_DOWN};
      res.frame_bad = 1'b1;
      last_keys = '0;
    end else begin
      keys = {frame_bytes[15], frame_bytes[14]};
      res.stick_0 = sticks[0];
      res.stick_1 = sticks[1];
      res.stick_2 = sticks[2];
      res.stick_3 = sticks[3];
      res.wheel_channel = {data, frame_bytes[16]} - {5'b0, cur_offset};
      res.switches_buttons = {frame_bytes[13] != 8'd0, frame_bytes[12] != 8'd0, sw_r, sw_l};
      res.mouse_x = {frame_bytes[7], frame_bytes[6]};
      res.mouse_y = {frame_bytes[9], frame_bytes[8]};
      res.mouse_z = {frame_bytes[11], frame_bytes[10]};
      res.key_bits = keys;
      res.key_rising = keys & ~last_keys;
      last_keys = keys;
    end
    expected_frames.push_back(res);
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic start);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(data, start);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input rfuc_frame_t fr, input bit with_start);
    int i;
    for (i = 0; i < FRAME_LEN; i++) send_byte(fr[i], with_start && i == 0);
  endtask

  // tail holds bytes 6..17, byte 6 in the low bits
  function automatic rfuc_frame_t build_frame(input logic [10:0] r0, r1, r2, r3,
                                              input logic [1:0] swl, swr,
                                              input logic [95:0] tail);
    rfuc_frame_t fr;
    fr[5:0]  = {swr, swl, r3, r2, r1, r0};
    fr[17:6] = tail;
    return fr;
  endfunction

  // mostly inside offset +/- limit, with the window edges and a few wild values
  function automatic logic [10:0] pick_raw();
    int lo;
    int hi;
    int r;
    lo = int'(cur_offset) - int'(cur_limit);
    hi = int'(cur_offset) + int'(cur_limit);
    if (lo < 0) lo = 0;
    if (hi > 2047) hi = 2047;
    r = $urandom_range(0, 59);
    if (r == 0) return 11'($urandom_range(0, 2047));
    if (r == 1 && hi < 2047) return 11'(hi + 1);
    if (r == 2 && lo > 0) return 11'(lo - 1);
    if (r == 3) return 11'(hi);
    if (r == 4) return 11'(lo);
    return 11'($urandom_range(hi, lo));
  endfunction

  function automatic logic [1:0] pick_switch();
    if ($urandom_range(0, 24) == 0) return 2'd0;
    return 2'($urandom_range(1, 3));
  endfunction

  function automatic rfuc_frame_t random_frame();
    logic [7:0]  b12;
    logic [7:0]  b13;
    logic [95:0] tail;
    b12 = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    b13 = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    tail = {16'($urandom), 16'($urandom), b13, b12, 16'($urandom), 16'($urandom),
            16'($urandom)};
    return build_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                       pick_switch(), pick_switch(), tail);
  endfunction

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    // a partial frame leaves nothing to wait for, give the pipeline time anyway
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [CH_W-1:0] off, input logic [CH_W-1:0] lim,
                              input bit with_spare);
    logic [CFG_IDX_W-1:0] idx_q[$];
    logic [CH_W-1:0]      val_q[$];
    int                   i;
    idx_q = '{CFG_CHANNEL_OFFSET, CFG_ERROR_LIMIT};
    val_q = '{off, lim};
    if (with_spare) begin
      idx_q.push_back(CFG_SPARE);
      val_q.push_back(11'($urandom));
    end
    for (i = 0; i < idx_q.size(); i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_q[i];
      cfg_data_i  <= val_q[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idx_q[i] == CFG_CHANNEL_OFFSET) cur_offset = val_q[i];
      else if (idx_q[i] == CFG_ERROR_LIMIT) cur_limit = val_q[i];
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // reset settings: unflagged bytes, restart mid-frame, range edges, switch faults, key edges
  task automatic test_directed_frames();
    int i;
    // no start flag after reset, sticks exactly at +/- limit, mouse extremes
    send_frame(build_frame(11'd1684, 11'd364, 11'd1024, 11'd1024, 2'd1, 2'd3,
                           {16'h0000, 16'hffff, 8'h00, 8'hff, 16'h0000, 16'h8000, 16'h7fff}),
               1'b0);
    // partial frame cut short by a new start
    send_byte(8'hff, 1'b1);
    for (i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    // one count over the limit
    send_frame(build_frame(11'd1685, 11'd1024, 11'd1024, 11'd1024, 2'd2, 2'd2,
                           {16'h1234, 16'h1234, 8'h01, 8'h01, 16'h1111, 16'h2222, 16'h3333}),
               1'b1);
    // left switch off
    send_frame(build_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd0, 2'd1,
                           {16'h5555, 16'h00ff, 8'h10, 8'h20, 16'h0001, 16'h0002, 16'h0003}),
               1'b1);
    // sticks far outside the window, then one count past -limit
    send_frame(build_frame(11'd0, 11'd2047, 11'd1023, 11'd1025, 2'd3, 2'd1,
                           {16'hffff, 16'ha5a5, 8'h80, 8'h00, 16'hffff, 16'h7fff, 16'h8000}),
               1'b1);
    send_frame(build_frame(11'd1024, 11'd363, 11'd1024, 11'd1024, 2'd1, 2'd1,
                           {16'h0400, 16'hffff, 8'h00, 8'h01, 16'h8000, 16'h0000, 16'hffff}),
               1'b1);
    send_frame(build_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd0,
                           {16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}),
               1'b1);
    drain_results();
  endtask

  task automatic test_register_extremes();
    logic [CH_W-1:0] offs[5];
    logic [CH_W-1:0] lims[5];
    int              s;
    int              n;
    offs = '{11'd0, 11'd2047, 11'd0, 11'd2047, OFFSET_RESET};
    lims = '{11'd0, 11'd0, 11'd2047, 11'd2047, LIMIT_RESET};
    for (s = 0; s < 5; s++) begin
      apply_config(offs[s], lims[s], s == 0);
      for (n = 0; n < 5; n++) send_frame(random_frame(), 1'b1);
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    int          phase;
    int unsigned phase_start;
    int          r;
    int          n;
    int          i;
    for (phase = 0; phase < 8; phase++) begin
      idle_en = (phase < 6);
      apply_config(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), phase == 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 150) begin
        r = $urandom_range(0, 19);
        if (r < 16) begin
          send_frame(random_frame(), $urandom_range(0, 3) != 0);
        end else if (r < 18) begin
          // broken frame, the next start flag throws it away
          send_byte(8'($urandom), 1'b1);
          n = $urandom_range(0, 15);
          for (i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
        end else begin
          n = $urandom_range(1, 24);
          for (i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CHANNEL_OFFSET;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_frames();
    test_register_extremes();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rfuc_pkg.sv
src/rfuc_byte_store.sv
src/rfuc_decode.sv
src/rfuc_result_stage.sv
src/remote_frame_unpack_check_core.sv
test/tb.sv
